// File: design/jtok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jtok_pkg;

  // Lexer modes
  localparam logic [3:0] M_START    = 4'd0;
  localparam logic [3:0] M_STRING   = 4'd1;
  localparam logic [3:0] M_ESCAPE   = 4'd2;
  localparam logic [3:0] M_UNICODE  = 4'd3;
  localparam logic [3:0] M_LITERAL  = 4'd4;
  localparam logic [3:0] M_NUMBER   = 4'd5;
  localparam logic [3:0] M_FRACTION = 4'd6;
  localparam logic [3:0] M_EXPONENT = 4'd7;
  localparam logic [3:0] M_DIGITS   = 4'd8;
  localparam logic [3:0] M_ERROR    = 4'd9;

  // Token types carried on end words
  localparam logic [2:0] TT_SYMBOL  = 3'd0;
  localparam logic [2:0] TT_STRING  = 3'd1;
  localparam logic [2:0] TT_NUMBER  = 3'd2;
  localparam logic [2:0] TT_FLOAT   = 3'd3;
  localparam logic [2:0] TT_NULL    = 3'd4;
  localparam logic [2:0] TT_BOOLEAN = 3'd5;
  localparam logic [2:0] TT_ERROR   = 3'd6;

  localparam int CpW     = 21;
  localparam int MaxRes  = 3;
  localparam int CntW    = 2;

  typedef logic [CpW-1:0] cp_t;

  typedef struct packed {
    cp_t        chr;
    logic       token_end;
    logic [2:0] token_type;
  } res_t;

  // One step of the lexer: how many words and their contents
  typedef struct packed {
    logic [CntW-1:0]    nres;
    res_t [MaxRes-1:0]  items;
  } step_t;

  function automatic cp_t ch(input logic [7:0] a);
    return {13'b0, a};
  endfunction

  function automatic logic is_digit(input cp_t c);
    return (c >= ch("0")) && (c <= ch("9"));
  endfunction

  function automatic logic is_ws(input cp_t c);
    return (c == ch(" ")) || (c == ch("\n")) || (c == ch("\r")) || (c == ch("\t"));
  endfunction

  function automatic logic is_punct(input cp_t c);
    return (c == ch(",")) || (c == ch(":")) || (c == ch("[")) || (c == ch("]")) ||
           (c == ch("{")) || (c == ch("}"));
  endfunction

  // Characters that end a bare word and are handled again from the start
  function automatic logic is_delim(input cp_t c);
    return is_punct(c) || (c == ch("\"")) || (c == ch("'"));
  endfunction

  function automatic logic hex_ok(input cp_t c);
    return is_digit(c) || ((c >= ch("a")) && (c <= ch("f"))) ||
           ((c >= ch("A")) && (c <= ch("F")));
  endfunction

  function automatic logic [3:0] hex_val(input cp_t c);
    logic [3:0] v;
    if (is_digit(c)) begin
      v = 4'(c - ch("0"));
    end else if ((c >= ch("a")) && (c <= ch("f"))) begin
      v = 4'(c - ch("a") + 21'd10);
    end else begin
      v = 4'(c - ch("A") + 21'd10);
    end
    return v;
  endfunction

  // Keyword spelling: 0 null, 1 true, 2 false
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] r;
    r = 8'd0;
    case (k)
      2'd0: begin
        case (pos)
          3'd0: r = "n";
          3'd1: r = "u";
          3'd2: r = "l";
          3'd3: r = "l";
          default: r = 8'd0;
        endcase
      end
      2'd1: begin
        case (pos)
          3'd0: r = "t";
          3'd1: r = "r";
          3'd2: r = "u";
          3'd3: r = "e";
          default: r = 8'd0;
        endcase
      end
      2'd2: begin
        case (pos)
          3'd0: r = "f";
          3'd1: r = "a";
          3'd2: r = "l";
          3'd3: r = "s";
          3'd4: r = "e";
          default: r = 8'd0;
        endcase
      end
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    return (k == 2'd2) ? 3'd5 : 3'd4;
  endfunction

  // Drop keywords that no longer match at this position
  function automatic logic [2:0] upd_cand(input logic [2:0] cand, input logic [2:0] pos,
                                          input cp_t c);
    logic [2:0] r;
    r = cand;
    for (int k = 0; k < 3; k++) begin
      if (cand[k] && ((pos >= kw_len(2'(k))) || (ch(kw_char(2'(k), pos)) != c))) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [2:0] word_type(input logic [2:0] cand, input logic [2:0] len);
    logic [2:0] t;
    if (cand[0] && (len == 3'd4)) begin
      t = TT_NULL;
    end else if (cand[1] && (len == 3'd4)) begin
      t = TT_BOOLEAN;
    end else if (cand[2] && (len == 3'd5)) begin
      t = TT_BOOLEAN;
    end else begin
      t = TT_STRING;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// File: design/json_tokenizer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming JSON lexer: one Unicode code point per input word, tokens out as
// character words followed by an end word that carries the token type. A
// code point is registered, decoded by the lexer in the next cycle and its
// zero to three result words land in a small output buffer, so a code point
// can be taken every cycle while the buffer has room. A code point holds the
// buffer until its last word leaves (up to three words: a number followed
// by e yields ".0e"), and the buffer drain sets the sustained throughput.
// The code point register and the output buffer lie between acceptance and
// the first result word. After a bad \u hex digit one error word is given
// and the block consumes all further input silently until reset.
module json_tokenizer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [20:0] in_code_point,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [20:0]      out_char_out,
  output logic             out_token_end,
  output logic [2:0]       out_token_type,
  output logic             out_last
);

  logic            s1_valid_r;
  jtok_pkg::cp_t   s1_cp_r;
  logic            s1_move;
  logic            buf_free;
  jtok_pkg::step_t res;
  jtok_pkg::res_t  item;

  // Move the registered code point on when its words have room
  assign s1_move  = s1_valid_r && ((res.nres == '0) || buf_free);
  assign in_ready = !s1_valid_r || s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cp_r <= in_code_point;
    end
  end

  jtok_lexer u_lexer (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_move),
    .cp    (s1_cp_r),
    .res   (res)
  );

  jtok_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_move && (res.nres != '0)),
    .res       (res),
    .free      (buf_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (item),
    .out_last  (out_last)
  );

  assign out_char_out   = item.chr;
  assign out_token_end  = item.token_end;
  assign out_token_type = item.token_type;

endmodule

`default_nettype wire

// File: design/jtok_lexer.sv
`timescale 1ns / 1ps
`default_nettype none

module jtok_lexer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire jtok_pkg::cp_t   cp,
  output jtok_pkg::step_t      res
);

  logic [3:0]  mode_r, mode_nxt;
  logic [15:0] hex_r, hex_nxt;
  logic [2:0]  hcnt_r, hcnt_nxt;
  logic [2:0]  cand_r, cand_nxt;
  logic [2:0]  wlen_r, wlen_nxt;

  logic            st_emit;
  logic            st_word;
  logic [3:0]      st_mode;
  jtok_pkg::res_t  st_item;

  // Effect of the code point when handled from the start state
  always_comb begin
    st_emit = 1'b0;
    st_word = 1'b0;
    st_mode = jtok_pkg::M_START;
    st_item = '{chr: cp, token_end: 1'b0, token_type: jtok_pkg::TT_SYMBOL};
    if (jtok_pkg::is_punct(cp)) begin
      st_emit = 1'b1;
      st_item.token_end = 1'b1;
    end else if (jtok_pkg::is_ws(cp)) begin
      st_mode = jtok_pkg::M_START;
    end else if (cp == jtok_pkg::ch("\"")) begin
      st_mode = jtok_pkg::M_STRING;
    end else if ((cp == jtok_pkg::ch("-")) || jtok_pkg::is_digit(cp)) begin
      st_emit = 1'b1;
      st_mode = jtok_pkg::M_NUMBER;
    end else begin
      st_emit = 1'b1;
      st_word = 1'b1;
      st_mode = jtok_pkg::M_LITERAL;
    end
  end

  // Decode one code point into up to three words and the next state
  always_comb begin
    logic [jtok_pkg::CntW-1:0] n;
    logic                      restart;
    logic [2:0]                rtype;
    jtok_pkg::res_t            it;
    logic [15:0]               hx;
    n        = '0;
    restart  = 1'b0;
    rtype    = jtok_pkg::TT_SYMBOL;
    hx       = {hex_r[11:0], jtok_pkg::hex_val(cp)};
    res      = '0;
    mode_nxt = mode_r;
    hex_nxt  = hex_r;
    hcnt_nxt = hcnt_r;
    cand_nxt = cand_r;
    wlen_nxt = wlen_r;
    it       = '{chr: cp, token_end: 1'b0, token_type: jtok_pkg::TT_SYMBOL};

    unique case (mode_r)
      jtok_pkg::M_START: begin
        mode_nxt = st_mode;
        if (st_emit) begin
          res.items[n] = st_item;
          n = n + 1'b1;
        end
        if (st_word) begin
          cand_nxt = jtok_pkg::upd_cand(3'b111, 3'd0, cp);
          wlen_nxt = 3'd1;
        end
      end
      jtok_pkg::M_STRING: begin
        if (cp == jtok_pkg::ch("\"")) begin
          res.items[n] = '{chr: '0, token_end: 1'b1, token_type: jtok_pkg::TT_STRING};
          n = n + 1'b1;
          mode_nxt = jtok_pkg::M_START;
        end else if (cp == jtok_pkg::ch("\\")) begin
          mode_nxt = jtok_pkg::M_ESCAPE;
        end else begin
          res.items[n] = it;
          n = n + 1'b1;
        end
      end
      jtok_pkg::M_ESCAPE: begin
        mode_nxt = jtok_pkg::M_STRING;
        if ((cp == jtok_pkg::ch("\"")) || (cp == jtok_pkg::ch("\\")) ||
            (cp == jtok_pkg::ch("/"))) begin
          res.items[n] = it;
          n = n + 1'b1;
        end else if (cp == jtok_pkg::ch("b")) begin
          it.chr = jtok_pkg::ch(8'd8);
          res.items[n] = it;
          n = n + 1'b1;
        end else if (cp == jtok_pkg::ch("f")) begin
          it.chr = jtok_pkg::ch(8'd12);
          res.items[n] = it;
          n = n + 1'b1;
        end else if (cp == jtok_pkg::ch("n")) begin
          it.chr = jtok_pkg::ch("\n");
          res.items[n] = it;
          n = n + 1'b1;
        end else if (cp == jtok_pkg::ch("r")) begin
          it.chr = jtok_pkg::ch("\r");
          res.items[n] = it;
          n = n + 1'b1;
        end else if (cp == jtok_pkg::ch("t")) begin
          it.chr = jtok_pkg::ch("\t");
          res.items[n] = it;
          n = n + 1'b1;
        end else if (cp == jtok_pkg::ch("u")) begin
          hex_nxt  = '0;
          hcnt_nxt = '0;
          mode_nxt = jtok_pkg::M_UNICODE;
        end
      end
      jtok_pkg::M_UNICODE: begin
        if (!jtok_pkg::hex_ok(cp)) begin
          res.items[n] = '{chr: '0, token_end: 1'b1, token_type: jtok_pkg::TT_ERROR};
          n = n + 1'b1;
          mode_nxt = jtok_pkg::M_ERROR;
        end else begin
          hex_nxt = hx;
          if (hcnt_r >= 3'd3) begin
            it.chr = {5'b0, hx};
            res.items[n] = it;
            n = n + 1'b1;
            hcnt_nxt = '0;
            mode_nxt = jtok_pkg::M_STRING;
          end else begin
            hcnt_nxt = hcnt_r + 3'd1;
          end
        end
      end
      jtok_pkg::M_LITERAL: begin
        if (jtok_pkg::is_ws(cp)) begin
          res.items[n] = '{chr: '0, token_end: 1'b1,
                           token_type: jtok_pkg::word_type(cand_r, wlen_r)};
          n = n + 1'b1;
          mode_nxt = jtok_pkg::M_START;
        end else if (jtok_pkg::is_delim(cp)) begin
          restart = 1'b1;
          rtype   = jtok_pkg::word_type(cand_r, wlen_r);
        end else begin
          cand_nxt = jtok_pkg::upd_cand(cand_r, wlen_r, cp);
          if (wlen_r < 3'd6) begin
            wlen_nxt = wlen_r + 3'd1;
          end
          res.items[n] = it;
          n = n + 1'b1;
        end
      end
      jtok_pkg::M_NUMBER: begin
        if (cp == jtok_pkg::ch(".")) begin
          res.items[n] = it;
          n = n + 1'b1;
          mode_nxt = jtok_pkg::M_FRACTION;
        end else if (jtok_pkg::is_digit(cp)) begin
          res.items[n] = it;
          n = n + 1'b1;
        end else if ((cp == jtok_pkg::ch("e")) || (cp == jtok_pkg::ch("E"))) begin
          // integer straight into exponent: insert ".0"
          res.items[0] = '{chr: jtok_pkg::ch("."), token_end: 1'b0,
                           token_type: jtok_pkg::TT_SYMBOL};
          res.items[1] = '{chr: jtok_pkg::ch("0"), token_end: 1'b0,
                           token_type: jtok_pkg::TT_SYMBOL};
          res.items[2] = it;
          n = 2'd3;
          mode_nxt = jtok_pkg::M_EXPONENT;
        end else begin
          restart = 1'b1;
          rtype   = jtok_pkg::TT_NUMBER;
        end
      end
      jtok_pkg::M_FRACTION: begin
        if (jtok_pkg::is_digit(cp)) begin
          res.items[n] = it;
          n = n + 1'b1;
        end else if ((cp == jtok_pkg::ch("e")) || (cp == jtok_pkg::ch("E"))) begin
          res.items[n] = it;
          n = n + 1'b1;
          mode_nxt = jtok_pkg::M_EXPONENT;
        end else begin
          restart = 1'b1;
          rtype   = jtok_pkg::TT_FLOAT;
        end
      end
      jtok_pkg::M_EXPONENT, jtok_pkg::M_DIGITS: begin
        mode_nxt = jtok_pkg::M_DIGITS;
        if (((mode_r == jtok_pkg::M_EXPONENT) &&
             ((cp == jtok_pkg::ch("+")) || (cp == jtok_pkg::ch("-")))) ||
            jtok_pkg::is_digit(cp)) begin
          res.items[n] = it;
          n = n + 1'b1;
        end else begin
          restart = 1'b1;
          rtype   = jtok_pkg::TT_FLOAT;
        end
      end
      default: begin
        mode_nxt = jtok_pkg::M_ERROR;
      end
    endcase

    // Close the open token, then handle the same code point from the start
    if (restart) begin
      res.items[0] = '{chr: '0, token_end: 1'b1, token_type: rtype};
      n = 2'd1;
      mode_nxt = st_mode;
      if (st_emit) begin
        res.items[1] = st_item;
        n = 2'd2;
      end
      if (st_word) begin
        cand_nxt = jtok_pkg::upd_cand(3'b111, 3'd0, cp);
        wlen_nxt = 3'd1;
      end
    end
    res.nres = n;
  end

  // Advance lexer state once per stepped code point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jtok_pkg::M_START;
      hex_r  <= '0;
      hcnt_r <= '0;
      cand_r <= 3'b111;
      wlen_r <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      hex_r  <= hex_nxt;
      hcnt_r <= hcnt_nxt;
      cand_r <= cand_nxt;
      wlen_r <= wlen_nxt;
    end
  end

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == jtok_pkg::M_ERROR) |=> (mode_r == jtok_pkg::M_ERROR))
    else $error("error mode left without reset");

  a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == jtok_pkg::M_ERROR) |-> (res.nres == '0))
    else $error("words produced in error mode");

endmodule

`default_nettype wire

// File: design/jtok_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none

module jtok_outbuf (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire jtok_pkg::step_t res,
  output logic                 free,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output jtok_pkg::res_t       out_item,
  output logic                 out_last
);

  jtok_pkg::res_t [jtok_pkg::MaxRes-1:0] items_r;
  logic [jtok_pkg::CntW-1:0]             cnt_r;
  logic [jtok_pkg::CntW-1:0]             idx_r;
  logic                                  valid_r;

  assign out_valid = valid_r;
  assign out_item  = items_r[idx_r];
  assign out_last  = (idx_r == cnt_r - 1'b1);
  // Buffer can take a new set when empty or when its final word leaves now
  assign free      = !valid_r || (out_ready && out_last);

  // Hold the result set of one code point and drain it a word at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      cnt_r   <= res.nres;
      idx_r   <= '0;
    end else if (valid_r && out_ready) begin
      if (out_last) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      items_r <= res.items;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (idx_r < cnt_r))
    else $error("output index beyond word count");

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (valid_r && (idx_r == '0)))
    else $error("loaded set not presented from its first word");

endmodule

`default_nettype wire
